// ===== design/ptm_pkg.sv =====
// Shared types and constants for the prescaled timer with match channels.
`timescale 1ns / 1ps

package ptm_pkg;

  localparam int DATA_W = 32;
  localparam int FLAG_W = 4;
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_WIDTH_DEF = 32;

  // request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // register map
  localparam logic [2:0] REG_RUN    = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_MATCH0 = 3'd2;
  localparam logic [2:0] REG_MCR    = 3'd6;
  localparam logic [2:0] REG_FLAGS  = 3'd7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        reg_index;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [FLAG_W-1:0] match_flags;
    logic              irq;
  } result_t;

  // handshake between the pipeline stages
  typedef struct packed {
    logic out_ready;
    logic fire;
  } pipe_ctl_t;

endpackage

// ===== design/ptm_in_stage.sv =====
// Input register stage: captures one request and holds it until it is processed.
`timescale 1ns / 1ps

module ptm_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptm_pkg::item_t    in_item,
  input  ptm_pkg::pipe_ctl_t ctl,
  output logic              item_valid,
  output ptm_pkg::item_t    item
);
  import ptm_pkg::*;

  logic  item_valid_r, item_valid_nxt;
  item_t item_r;

  // full stage that cannot drain this cycle holds the sender
  assign in_stall = item_valid_r & ~ctl.out_ready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (!in_stall) begin
      item_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

// ===== design/ptm_core.sv =====
// Timer state, register file and the single-pass update for one request.
`timescale 1ns / 1ps

module ptm_core #(
  parameter int NUM_CHANNELS = ptm_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = ptm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ptm_pkg::DATA_W-1:0] cfg_data,
  input  ptm_pkg::pipe_ctl_t         ctl,
  input  ptm_pkg::item_t             item,
  output ptm_pkg::result_t           result
);
  import ptm_pkg::*;

  localparam int MCR_W = 3 * NUM_CHANNELS;

  logic [DATA_W-1:0]      prescale_r;
  logic                   run_r, run_nxt;
  logic [DATA_W-1:0]      pcount_r, pcount_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] match_r   [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] match_nxt [NUM_CHANNELS];
  logic [MCR_W-1:0]       mcr_r, mcr_nxt;
  logic [NUM_CHANNELS-1:0] flags_r, flags_nxt;
  logic [DATA_W-1:0]      rd;

  always_comb begin
    run_nxt    = run_r;
    pcount_nxt = pcount_r;
    count_nxt  = count_r;
    mcr_nxt    = mcr_r;
    flags_nxt  = flags_r;
    rd         = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      match_nxt[i] = match_r[i];
    end

    case (item.kind)
      KIND_TICK: begin
        if (run_r) begin
          // also reloads when prescale was lowered below the counter
          if (pcount_r >= prescale_r) begin
            pcount_nxt = '0;
            count_nxt  = count_r + 1'b1;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (mcr_r[3*i] && (match_r[i] == count_nxt)) begin
                flags_nxt[i] = 1'b1;
              end
            end
          end else begin
            pcount_nxt = pcount_r + 1'b1;
          end
        end
      end
      KIND_READ: begin
        case (item.reg_index)
          REG_RUN:   rd = DATA_W'(run_r);
          REG_COUNT: rd = DATA_W'(count_r);
          REG_MCR:   rd = DATA_W'(mcr_r);
          REG_FLAGS: rd = DATA_W'(flags_r);
          default: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (item.reg_index == 3'(REG_MATCH0 + i)) begin
                rd = DATA_W'(match_r[i]);
              end
            end
          end
        endcase
      end
      KIND_WRITE: begin
        case (item.reg_index)
          REG_RUN:   run_nxt   = item.write_data[0];
          REG_COUNT: count_nxt = item.write_data[COUNT_WIDTH-1:0];
          REG_MCR:   mcr_nxt   = item.write_data[MCR_W-1:0];
          REG_FLAGS: flags_nxt = flags_r & ~item.write_data[NUM_CHANNELS-1:0];
          default: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (item.reg_index == 3'(REG_MATCH0 + i)) begin
                match_nxt[i] = item.write_data[COUNT_WIDTH-1:0];
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign result.read_data   = rd;
  assign result.match_flags = FLAG_W'(flags_nxt);
  assign result.irq         = |flags_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      run_r      <= 1'b0;
      pcount_r   <= '0;
      count_r    <= '0;
      mcr_r      <= '0;
      flags_r    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        match_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        prescale_r <= cfg_data;
      end
      if (ctl.fire) begin
        run_r    <= run_nxt;
        pcount_r <= pcount_nxt;
        count_r  <= count_nxt;
        mcr_r    <= mcr_nxt;
        flags_r  <= flags_nxt;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          match_r[i] <= match_nxt[i];
        end
      end
    end
  end

endmodule

// ===== design/ptm_out_stage.sv =====
// Result register: holds one result until the receiver takes it.
`timescale 1ns / 1ps

module ptm_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  ptm_pkg::pipe_ctl_t ctl,
  input  ptm_pkg::result_t   result,
  output logic               out_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output ptm_pkg::result_t   out_result
);
  import ptm_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t result_r;

  assign out_ready = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = ctl.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      result_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

// ===== design/prescaled_timer_match_channels.sv =====
// Path: a request enters the input register, then the result register when it fires.
// Throughput: one request per cycle while out_stall is low; the input register and the result register
//   each take a new request whenever the stage ahead drains in the same cycle.
// A stalled result holds the result register and, once the input register is full,
//   the input side. Synchronous active-low reset clears the timer state, the
//   prescale register and both stage valids; the prescale write port is always ready.
`timescale 1ns / 1ps

module prescaled_timer_match_channels #(
  parameter int NUM_CHANNELS = ptm_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = ptm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_kind,
  input  logic [2:0]                 in_reg_index,
  input  logic [ptm_pkg::DATA_W-1:0] in_write_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ptm_pkg::DATA_W-1:0] out_read_data,
  output logic [ptm_pkg::FLAG_W-1:0] out_match_flags,
  output logic                       out_irq,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ptm_pkg::DATA_W-1:0] cfg_data
);
  import ptm_pkg::*;

  item_t     in_item;
  item_t     item;
  logic      item_valid;
  logic      out_ready;
  pipe_ctl_t ctl;
  result_t   result;
  result_t   out_result;

  assign in_item.kind       = in_kind;
  assign in_item.reg_index  = in_reg_index;
  assign in_item.write_data = in_write_data;

  assign ctl.out_ready = out_ready;
  assign ctl.fire      = item_valid & out_ready;

  assign cfg_ready = 1'b1;

  ptm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .ctl        (ctl),
    .item_valid (item_valid),
    .item       (item)
  );

  ptm_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .item     (item),
    .result   (result)
  );

  ptm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_read_data   = out_result.read_data;
  assign out_match_flags = out_result.match_flags;
  assign out_irq         = out_result.irq;

  // a processed request always lands in the result register
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire |=> out_valid)
    else $error("processed request did not reach the result register");

  // input side is only held back by a full input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid)
    else $error("input stalled with an empty input register");

  // irq tracks the pending flags in every result
  a_irq_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_irq == (out_match_flags != '0)))
    else $error("irq does not match pending flags");

  // flags of absent channels never show
  a_absent_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_match_flags >> NUM_CHANNELS) == '0))
    else $error("flag set for an absent channel");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !item_valid))
    else $error("stage valid set after reset");

endmodule
